@@ design/rpbms_pkg.sv @@
// Package with shared types and codes for the rood pattern block motion search.
package rpbms_pkg;

  typedef enum logic [1:0] {
    CMD_WR_REF = 2'd0,
    CMD_WR_TGT = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_BLOCK  = 2'd2;
  localparam logic [1:0] REG_RADIUS = 2'd3;

  localparam int CFG_W  = 9;
  localparam int COST_W = 24;

endpackage

@@ design/rood_pattern_block_motion_search_top.sv @@
// Top level of the rood pattern block motion search with frame memories and search sequencer.
// Channel | Direction | Contents
// in_*    | input     | tdata: command[1:0] row[9:2] col[17:10] pixel[25:18] pred_dy[31:26]
//         |           |        pred_dx[37:32], zero padded to 40 bits
// out_*   | output    | tdata: motion_dy[5:0] motion_dx[11:6] match_row[19:12]
//         |           |        match_col[27:20] best_cost[51:28], zero padded to 56 bits
// cfg_*   | input     | we, idx[1:0], data[8:0]
// A pixel write is accepted whenever in_tready is high, and the next transfer may follow at once.
// A search first clears the visited map, then for each evaluated candidate alternates a
// frame read state and a multiply accumulate state per pixel pair; a candidate that fails
// the checks is skipped, one already visited is skipped after its map read, and each
// pattern step ends with a pick of the best.
// Reset is synchronous and active low; frames are not cleared. in_tready is low while a
// search runs or while a result waits on out_tready.
module rood_pattern_block_motion_search_top #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_BLOCK  = 16,
  parameter int MAX_RADIUS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // command, row, col, pixel, pred_dy, pred_dx
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // motion_dy, motion_dx, match_row, match_col, best_cost
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [rpbms_pkg::CFG_W-1:0] cfg_data
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_COLS);
  localparam int AW   = RW + CW;
  localparam int WS   = 2 * MAX_RADIUS + 1;
  localparam int MAPD = WS * WS;
  localparam int MW   = $clog2(MAPD);
  localparam int BW   = $clog2(MAX_BLOCK + 1);
  localparam int DW   = $clog2(MAX_RADIUS + 1) + 1;
  localparam int PW   = (RW > CW ? RW : CW) + 3;
  localparam int SUMW = 2 * BW + 17;
  localparam int KW   = $clog2(MAX_BLOCK);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_PREP, S_CHK, S_MAPRD, S_MAPCHK, S_RD, S_ACC, S_NEXT,
    S_PICK, S_OUT
  } state_t;

  state_t state_r;

  logic [8:0] rows_r, cols_r;
  logic [BW-1:0] bsz_r;
  logic [DW-1:0] rad_r;

  logic [7:0] ref_mem [MAX_ROWS*MAX_COLS];
  logic [7:0] tgt_mem [MAX_ROWS*MAX_COLS];
  logic       map_mem [MAPD];

  logic [7:0] ref_q_r, tgt_q_r;
  logic       map_q_r;

  logic signed [PW-1:0] org_r_r, org_c_r, cen_r_r, cen_c_r, cand_r_r, cand_c_r;
  logic signed [DW:0]   pdy_r, pdx_r, step_r;
  logic [2:0]  k_r, cnt_r;
  logic        large_r;
  logic [SUMW-1:0] acc_r;
  logic [SUMW-1:0] cost_r [6];
  logic [5:0]  cval_r;
  logic [KW:0] pr_r, pc_r;
  logic [MW-1:0] mapa_r;
  logic        first_r;
  logic [55:0] out_r;
  logic        outv_r;

  logic [1:0] cmd_w;
  logic [7:0] row_w, col_w, pix_w;
  logic signed [5:0] pdy_w, pdx_w;
  assign cmd_w = in_tdata[1:0];
  assign row_w = in_tdata[9:2];
  assign col_w = in_tdata[17:10];
  assign pix_w = in_tdata[25:18];
  assign pdy_w = in_tdata[31:26];
  assign pdx_w = in_tdata[37:32];

  logic in_acc;
  assign in_tready = (state_r == S_IDLE) && !outv_r;
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = outv_r;
  assign out_tdata = out_r;

  // Candidate offsets by pattern index.
  logic signed [PW-1:0] ody, odx;
  always_comb begin
    ody = '0;
    odx = '0;
    case (k_r)
      3'd0: ody = large_r ? -PW'(step_r) : -PW'(1);
      3'd1: odx = large_r ? -PW'(step_r) : -PW'(1);
      3'd3: odx = large_r ? PW'(step_r) : PW'(1);
      3'd4: ody = large_r ? PW'(step_r) : PW'(1);
      3'd5: begin
        ody = PW'(pdy_r);
        odx = PW'(pdx_r);
      end
      default: ;
    endcase
  end

  logic signed [PW-1:0] ty, tx, dyo, dxo, rads;
  logic ok;
  always_comb begin
    ty   = cen_r_r + ody;
    tx   = cen_c_r + odx;
    dyo  = ty - org_r_r;
    dxo  = tx - org_c_r;
    rads = PW'(rad_r);
    ok   = (ty >= 0) && (tx >= 0) &&
           (ty + PW'(bsz_r) <= PW'(rows_r)) && (tx + PW'(bsz_r) <= PW'(cols_r)) &&
           (dyo <= rads) && (dyo >= -rads) &&
           (dxo <= rads) && (dxo >= -rads);
  end

  logic [AW-1:0] ra, ta;
  always_comb begin
    ra = AW'(org_r_r + PW'(pr_r)) * AW'(MAX_COLS) + AW'(org_c_r + PW'(pc_r));
    ta = AW'(cand_r_r + PW'(pr_r)) * AW'(MAX_COLS) + AW'(cand_c_r + PW'(pc_r));
  end

  logic signed [8:0] dif;
  logic [15:0] sq;
  assign dif = $signed({1'b0, ref_q_r}) - $signed({1'b0, tgt_q_r});
  assign sq  = 16'(dif * dif);

  // Pick lowest cost, earliest index on ties; centre is the default.
  logic [2:0] best;
  always_comb begin
    best = 3'd2;
    for (int k = 0; k < 6; k++) begin
      if (cval_r[k] && (cost_r[k] < cost_r[best] ||
          (cost_r[k] == cost_r[best] && 3'(k) < best))) best = 3'(k);
    end
  end

  logic signed [DW:0] cpy, cpx, ay, ax;
  always_comb begin
    cpy = (pdy_w > $signed({1'b0, rad_r})) ? $signed({1'b0, rad_r}) :
          (pdy_w < -$signed({1'b0, rad_r})) ? -$signed({1'b0, rad_r}) : (DW+1)'(pdy_w);
    cpx = (pdx_w > $signed({1'b0, rad_r})) ? $signed({1'b0, rad_r}) :
          (pdx_w < -$signed({1'b0, rad_r})) ? -$signed({1'b0, rad_r}) : (DW+1)'(pdx_w);
    ay  = cpy < 0 ? -cpy : cpy;
    ax  = cpx < 0 ? -cpx : cpx;
  end

  logic org_fit;
  assign org_fit = (9'(row_w) + 9'(bsz_r) <= rows_r) && (9'(col_w) + 9'(bsz_r) <= cols_r);

  logic [MW-1:0] tmap;
  assign tmap = MW'((32'(dyo) + MAX_RADIUS) * WS + (32'(dxo) + MAX_RADIUS));

  logic map_we;
  logic [MW-1:0] map_wa;
  logic map_wd;
  always_comb begin
    map_we = 1'b0;
    map_wa = mapa_r;
    map_wd = 1'b0;
    if (state_r == S_CLR) map_we = 1'b1;
    else if (state_r == S_MAPCHK && !map_q_r) begin
      map_we = 1'b1;
      map_wd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && 32'(row_w) < MAX_ROWS && 32'(col_w) < MAX_COLS) begin
      if (cmd_w == rpbms_pkg::CMD_WR_REF)
        ref_mem[AW'(row_w) * AW'(MAX_COLS) + AW'(col_w)] <= pix_w;
      if (cmd_w == rpbms_pkg::CMD_WR_TGT)
        tgt_mem[AW'(row_w) * AW'(MAX_COLS) + AW'(col_w)] <= pix_w;
    end
    ref_q_r <= ref_mem[ra];
    tgt_q_r <= tgt_mem[ta];
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q_r <= map_mem[mapa_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 9'(MAX_ROWS < 256 ? MAX_ROWS : 256);
      cols_r <= 9'(MAX_COLS < 256 ? MAX_COLS : 256);
      bsz_r <= BW'(MAX_BLOCK < 8 ? MAX_BLOCK : 8);
      rad_r <= DW'(MAX_RADIUS < 7 ? MAX_RADIUS : 7);
    end else if (cfg_we) begin
      case (cfg_idx)
        rpbms_pkg::REG_ROWS:
          rows_r <= cfg_data == 0 ? 9'd1 : (32'(cfg_data) > MAX_ROWS ? 9'(MAX_ROWS) : cfg_data);
        rpbms_pkg::REG_COLS:
          cols_r <= cfg_data == 0 ? 9'd1 : (32'(cfg_data) > MAX_COLS ? 9'(MAX_COLS) : cfg_data);
        rpbms_pkg::REG_BLOCK:
          bsz_r <= cfg_data[4:0] == 0 ? BW'(1) :
                   (32'(cfg_data[4:0]) > MAX_BLOCK ? BW'(MAX_BLOCK) : BW'(cfg_data[4:0]));
        rpbms_pkg::REG_RADIUS:
          rad_r <= 32'(cfg_data[4:0]) > MAX_RADIUS ? DW'(MAX_RADIUS) : DW'(cfg_data[4:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r <= 1'b0;
    end else begin
      if (outv_r && out_tready) outv_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc && cmd_w == rpbms_pkg::CMD_SEARCH && org_fit) begin
            org_r_r <= PW'(row_w);
            org_c_r <= PW'(col_w);
            cen_r_r <= PW'(row_w);
            cen_c_r <= PW'(col_w);
            cand_r_r <= PW'(row_w);
            cand_c_r <= PW'(col_w);
            pdy_r <= cpy;
            pdx_r <= cpx;
            if (col_w == 0) begin
              step_r <= (DW+1)'(2);
              cnt_r <= 3'd5;
            end else begin
              step_r <= ax <= ay ? ay : ax;
              cnt_r <= ((ax >= ay && ay == 0) || (ax == 0)) ? 3'd5 : 3'd6;
            end
            mapa_r <= '0;
            state_r <= S_CLR;
          end
        end
        S_CLR: begin
          if (32'(mapa_r) == MAPD - 1) begin
            mapa_r <= MW'(MAX_RADIUS * WS + MAX_RADIUS);
            state_r <= S_PREP;
          end else mapa_r <= mapa_r + 1'b1;
        end
        S_PREP: begin
          // Origin cost: mark visited, then accumulate into the centre slot.
          k_r <= 3'd2;
          large_r <= 1'b1;
          first_r <= 1'b1;
          cval_r <= '0;
          state_r <= S_MAPRD;
        end
        S_CHK: begin
          if (k_r == 3'd2 || 32'(k_r) >= 32'(cnt_r) || (large_r && step_r == 0) || !ok)
            state_r <= S_NEXT;
          else begin
            cand_r_r <= ty;
            cand_c_r <= tx;
            mapa_r <= tmap;
            state_r <= S_MAPRD;
          end
        end
        S_MAPRD: state_r <= S_MAPCHK;
        S_MAPCHK: begin
          if (map_q_r) state_r <= S_NEXT;
          else begin
            pr_r <= '0;
            pc_r <= '0;
            acc_r <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_ACC;
        S_ACC: begin
          acc_r <= acc_r + SUMW'(sq);
          if (pc_r + 1'b1 == (KW+1)'(bsz_r)) begin
            pc_r <= '0;
            if (pr_r + 1'b1 == (KW+1)'(bsz_r)) begin
              cost_r[k_r] <= acc_r + SUMW'(sq);
              cval_r[k_r] <= 1'b1;
              state_r <= first_r ? S_CHK : S_NEXT;
              if (first_r) begin
                first_r <= 1'b0;
                k_r <= 3'd0;
              end
            end else begin
              pr_r <= pr_r + 1'b1;
              state_r <= S_RD;
            end
          end else begin
            pc_r <= pc_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_NEXT: begin
          if (k_r == 3'd5) state_r <= S_PICK;
          else begin
            k_r <= k_r + 1'b1;
            state_r <= S_CHK;
          end
        end
        S_PICK: begin
          if (!large_r && best == 3'd2) state_r <= S_OUT;
          else begin
            if (large_r) begin
              cen_r_r <= cen_r_r + (best == 3'd0 ? -PW'(step_r) :
                         best == 3'd4 ? PW'(step_r) : best == 3'd5 ? PW'(pdy_r) : '0);
              cen_c_r <= cen_c_r + (best == 3'd1 ? -PW'(step_r) :
                         best == 3'd3 ? PW'(step_r) : best == 3'd5 ? PW'(pdx_r) : '0);
            end else begin
              cen_r_r <= cen_r_r + (best == 3'd0 ? -PW'(1) : best == 3'd4 ? PW'(1) : '0);
              cen_c_r <= cen_c_r + (best == 3'd1 ? -PW'(1) : best == 3'd3 ? PW'(1) : '0);
            end
            cost_r[2] <= cost_r[best];
            cval_r <= 6'b000100;
            large_r <= 1'b0;
            cnt_r <= 3'd5;
            k_r <= 3'd0;
            state_r <= S_CHK;
          end
        end
        S_OUT: begin
          out_r <= {4'd0, rpbms_pkg::COST_W'(cost_r[2]), 8'(cen_c_r), 8'(cen_r_r),
                    6'(cen_c_r - org_c_r), 6'(cen_r_r - org_r_r)};
          outv_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/rpbms_checker.sv @@
// Port checker for the rood pattern block motion search top level, with its bind.
module rpbms_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result changed while stalled.");

  a_no_in_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("Input taken while a result waits.");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:52] == 4'd0)
    else $error("Padding bits set.");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result valid after reset.");

endmodule

bind rood_pattern_block_motion_search_top rpbms_props u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ test/rpbms_checker.sv @@
// Checker that predicts motion search results from the observed channels and compares them.
`timescale 1ns / 100ps
module rpbms_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [39:0]      in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [55:0]      out_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [rpbms_pkg::CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);
  localparam int FRAME_COLS = 256;
  localparam int RAD_MAX    = 16;
  localparam int WIN        = 2 * RAD_MAX + 1;

  typedef struct packed {
    logic [23:0]       cost;
    logic [7:0]        mcol;
    logic [7:0]        mrow;
    logic signed [5:0] dx;
    logic signed [5:0] dy;
  } motion_t;

  logic [7:0] ref_px [65536];
  logic [7:0] tgt_px [65536];
  bit visited [WIN*WIN];
  longint unsigned cand_cost [6];
  bit cand_ok [6];
  int rows_cfg, cols_cfg, bsize_cfg, radius_cfg;
  int org_r, org_c;
  motion_t motion_q [$];

  assign pending = motion_q.size();

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned block_sse(int ty, int tx);
    longint unsigned sum;
    int d;
    sum = 0;
    for (int r = 0; r < bsize_cfg; r++) begin
      for (int c = 0; c < bsize_cfg; c++) begin
        d = int'(ref_px[(org_r + r) * FRAME_COLS + org_c + c]) -
            int'(tgt_px[(ty + r) * FRAME_COLS + tx + c]);
        sum += longint'(d * d);
      end
    end
    return sum;
  endfunction

  function automatic bit fits_frame(int ty, int tx);
    return ty >= 0 && tx >= 0 && ty + bsize_cfg <= rows_cfg && tx + bsize_cfg <= cols_cfg;
  endfunction

  function automatic int win_index(int ty, int tx);
    return (ty - org_r + RAD_MAX) * WIN + (tx - org_c + RAD_MAX);
  endfunction

  function automatic void probe(int k, int ty, int tx);
    int m;
    if (!fits_frame(ty, tx)) return;
    if (iabs(ty - org_r) > radius_cfg || iabs(tx - org_c) > radius_cfg) return;
    m = win_index(ty, tx);
    if (visited[m]) return;
    cand_cost[k] = block_sse(ty, tx);
    cand_ok[k] = 1;
    visited[m] = 1;
  endfunction

  function automatic int pick(int n);
    int b;
    b = 2;
    for (int k = 0; k < n; k++) begin
      if (cand_ok[k] && (cand_cost[k] < cand_cost[b] ||
          (cand_cost[k] == cand_cost[b] && k < b)))
        b = k;
    end
    return b;
  endfunction

  function automatic void reset_cands(longint unsigned centre);
    for (int k = 0; k < 6; k++) begin
      cand_ok[k] = 0;
      cand_cost[k] = 0;
    end
    cand_cost[2] = centre;
    cand_ok[2] = 1;
  endfunction

  function automatic bit search_motion(int row, int col, int py, int px, output motion_t m);
    int pdy, pdx, stp, cnt, ay, ax, b, cr, cc;
    int ldy [6];
    int ldx [6];
    int sdy [5];
    int sdx [5];
    longint unsigned cost;
    sdy = '{-1, 0, 0, 0, 1};
    sdx = '{0, -1, 0, 1, 0};
    m = '0;
    org_r = row;
    org_c = col;
    if (!fits_frame(row, col)) return 0;
    pdy = clip(py, -radius_cfg, radius_cfg);
    pdx = clip(px, -radius_cfg, radius_cfg);
    foreach (visited[i]) visited[i] = 0;
    reset_cands(block_sse(row, col));
    visited[win_index(row, col)] = 1;
    if (col == 0) begin
      stp = 2;
      cnt = 5;
    end else begin
      ay = iabs(pdy);
      ax = iabs(pdx);
      stp = ax <= ay ? ay : ax;
      cnt = ((ax == stp && ay == 0) || (ax == 0 && ay == stp)) ? 5 : 6;
    end
    ldy = '{-stp, 0, 0, 0, stp, pdy};
    ldx = '{0, -stp, 0, stp, 0, pdx};
    if (stp != 0) begin
      for (int k = 0; k < cnt; k++)
        if (k != 2) probe(k, row + ldy[k], col + ldx[k]);
    end
    b = pick(cnt);
    cr = row + ldy[b];
    cc = col + ldx[b];
    cost = cand_cost[b];
    forever begin
      reset_cands(cost);
      for (int k = 0; k < 5; k++)
        if (k != 2) probe(k, cr + sdy[k], cc + sdx[k]);
      b = pick(5);
      if (b == 2) break;
      cr += sdy[b];
      cc += sdx[b];
      cost = cand_cost[b];
    end
    m.dy   = 6'(cr - row);
    m.dx   = 6'(cc - col);
    m.mrow = 8'(cr);
    m.mcol = 8'(cc);
    m.cost = cost[23:0];
    return 1;
  endfunction

  always @(posedge clk) begin
    rpbms_pkg::cmd_t cmd;
    int row, col, py, px;
    motion_t m, got, exp_m;
    if (!rst_n) begin
      rows_cfg   <= 256;
      cols_cfg   <= 256;
      bsize_cfg  <= 8;
      radius_cfg <= 7;
      errors     <= 0;
      motion_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          rpbms_pkg::REG_ROWS:   rows_cfg   <= clip(int'(cfg_data), 1, 256);
          rpbms_pkg::REG_COLS:   cols_cfg   <= clip(int'(cfg_data), 1, 256);
          rpbms_pkg::REG_BLOCK:  bsize_cfg  <= clip(int'(cfg_data[4:0]), 1, 16);
          rpbms_pkg::REG_RADIUS: radius_cfg <= clip(int'(cfg_data[4:0]), 0, 16);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        cmd = rpbms_pkg::cmd_t'(in_tdata[1:0]);
        row = in_tdata[9:2];
        col = in_tdata[17:10];
        py  = $signed(in_tdata[31:26]);
        px  = $signed(in_tdata[37:32]);
        case (cmd)
          rpbms_pkg::CMD_WR_REF: ref_px[row * FRAME_COLS + col] = in_tdata[25:18];
          rpbms_pkg::CMD_WR_TGT: tgt_px[row * FRAME_COLS + col] = in_tdata[25:18];
          rpbms_pkg::CMD_SEARCH:
            if (search_motion(row, col, py, px, m)) motion_q.push_back(m);
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[51:0];
        if (motion_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp_m = motion_q.pop_front();
          if (got.dy !== exp_m.dy)
            $display("%0t: motion_dy expected %0d actual %0d", $time, exp_m.dy, got.dy);
          if (got.dx !== exp_m.dx)
            $display("%0t: motion_dx expected %0d actual %0d", $time, exp_m.dx, got.dx);
          if (got.mrow !== exp_m.mrow)
            $display("%0t: match_row expected %0d actual %0d", $time, exp_m.mrow, got.mrow);
          if (got.mcol !== exp_m.mcol)
            $display("%0t: match_col expected %0d actual %0d", $time, exp_m.mcol, got.mcol);
          if (got.cost !== exp_m.cost)
            $display("%0t: best_cost expected %0d actual %0d", $time, exp_m.cost, got.cost);
          if (got !== exp_m) errors <= errors + 1;
        end
      end
    end
  end
endmodule

@@ test/rood_pattern_block_motion_search_top_tb.sv @@
// Testbench top that drives frame loads, searches and register settings and reports the verdict.
`timescale 1ns / 100ps
module rood_pattern_block_motion_search_top_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [rpbms_pkg::CFG_W-1:0] cfg_data;
  int errors, pending;
  int idle_pct;
  bit hold_go;
  int stall_cnt;
  bit ref_w [65536];
  bit tgt_w [65536];
  int rows_cur, cols_cur, bs_cur, rad_cur;
  int span;

  rood_pattern_block_motion_search_top dut (.*);

  rpbms_checker chk (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic logic [39:0] pack_item(rpbms_pkg::cmd_t cmd, int row, int col, int pix,
                                            int py, int px);
    return {2'b0, 6'(px), 6'(py), 8'(pix), 8'(col), 8'(row), 2'(cmd)};
  endfunction

  task automatic send(logic [39:0] d);
    int r, c;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = d[9:2];
    c = d[17:10];
    if (rpbms_pkg::cmd_t'(d[1:0]) == rpbms_pkg::CMD_WR_REF) ref_w[r * 256 + c] = 1;
    if (rpbms_pkg::cmd_t'(d[1:0]) == rpbms_pkg::CMD_WR_TGT) tgt_w[r * 256 + c] = 1;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !in_tready) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, int val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= rpbms_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic configure(int rows, int cols, int bs, int rad);
    settle();
    cfg_write(rpbms_pkg::REG_ROWS, rows);
    cfg_write(rpbms_pkg::REG_COLS, cols);
    cfg_write(rpbms_pkg::REG_BLOCK, bs);
    cfg_write(rpbms_pkg::REG_RADIUS, rad);
    rows_cur = clip(rows & 511, 1, 256);
    cols_cur = clip(cols & 511, 1, 256);
    bs_cur   = clip(bs & 31, 1, 16);
    rad_cur  = clip(rad & 31, 0, 16);
  endtask

  // Loads every pixel a search at this corner can read that has not been written yet.
  task automatic search(int row, int col, int py, int px);
    int r0, r1, c0, c1;
    if (row + bs_cur <= rows_cur && col + bs_cur <= cols_cur) begin
      r0 = clip(row - rad_cur, 0, 255);
      r1 = clip(row + rad_cur + bs_cur - 1, 0, rows_cur - 1);
      c0 = clip(col - rad_cur, 0, 255);
      c1 = clip(col + rad_cur + bs_cur - 1, 0, cols_cur - 1);
      for (int r = r0; r <= r1; r++) begin
        for (int c = c0; c <= c1; c++) begin
          if (!ref_w[r * 256 + c])
            send(pack_item(rpbms_pkg::CMD_WR_REF, r, c, $urandom_range(255), 0, 0));
          if (!tgt_w[r * 256 + c])
            send(pack_item(rpbms_pkg::CMD_WR_TGT, r, c, $urandom_range(255), 0, 0));
        end
      end
    end
    send(pack_item(rpbms_pkg::CMD_SEARCH, row, col, $urandom_range(255), py, px));
  endtask

  // Most corners stay in the top left part of the frame so that few pixels need loading.
  task automatic random_search();
    int row, col, py, px, sel, lim_r, lim_c;
    sel = $urandom_range(9);
    lim_r = rows_cur < span ? rows_cur : span;
    lim_c = cols_cur < span ? cols_cur : span;
    row = $urandom_range(lim_r > bs_cur ? lim_r - bs_cur : 0);
    col = $urandom_range(lim_c > bs_cur ? lim_c - bs_cur : 0);
    if (sel == 0) col = 0;
    if (sel == 1) begin
      row = $urandom_range(255);
      col = $urandom_range(255);
    end
    if ($urandom_range(9) < 7) begin
      py = $urandom_range(2 * rad_cur) - rad_cur;
      px = $urandom_range(2 * rad_cur) - rad_cur;
    end else begin
      py = $signed(6'($urandom));
      px = $signed(6'($urandom));
    end
    search(row, col, py, px);
  endtask

  task automatic noise();
    logic [39:0] d;
    d = 40'($urandom) | (40'($urandom_range(255)) << 32);
    if ($urandom_range(3) == 0) d[1:0] = rpbms_pkg::CMD_NONE;
    else d[1:0] = $urandom_range(1) ? rpbms_pkg::CMD_WR_TGT : rpbms_pkg::CMD_WR_REF;
    send(d);
  endtask

  task automatic phase(int rows, int cols, int bs, int rad, int n_srch, int n_noise);
    int s, n;
    configure(rows, cols, bs, rad);
    s = 0;
    n = 0;
    while (s < n_srch || n < n_noise) begin
      if (n >= n_noise || (s < n_srch && $urandom_range(2) == 0)) begin
        random_search();
        s++;
      end else begin
        noise();
        n++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= 2000000) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    bit held;
    held = 0;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go && !held) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= idle_pct);
      @(posedge clk);
    end
  end

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_idx   = rpbms_pkg::REG_ROWS;
    cfg_data  = '0;
    rst_n     = 1'b0;
    idle_pct  = 27;
    hold_go   = 0;
    span      = 10;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(10, 10, 3, 4);
    send(pack_item(rpbms_pkg::CMD_WR_REF, 255, 255, 255, 0, 0));
    send(pack_item(rpbms_pkg::CMD_WR_TGT, 255, 255, 0, 0, 0));
    send(pack_item(rpbms_pkg::CMD_WR_REF, 0, 0, 0, 0, 0));
    send(pack_item(rpbms_pkg::CMD_WR_TGT, 0, 0, 255, 0, 0));
    send(pack_item(rpbms_pkg::CMD_NONE, 255, 255, 255, -1, -1));
    search(0, 0, 0, 0);
    search(4, 4, 0, 0);
    search(4, 4, 3, 0);
    search(4, 4, 0, -2);
    search(4, 4, 2, -3);
    search(5, 3, -32, 31);
    search(3, 5, 31, -32);
    search(7, 7, -4, -4);
    search(8, 2, 1, 1);
    search(2, 8, 1, 1);
    search(0, 0, 4, 4);
    search(6, 0, -4, 0);

    phase(256, 256, 1, 0, 6, 10);
    phase(10, 10, 2, 1, 8, 10);
    idle_pct = 0;
    phase(10, 10, 2, 16, 4, 8);
    idle_pct = 27;
    settle();
    phase(10, 10, 2, 16, 4, 8);
    phase(10, 10, 31, 3, 2, 4);
    phase(0, 511, 0, 31, 4, 8);
    configure(10, 10, 3, 2);
    hold_go = 1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) random_search();
      else noise();
    end
    phase(300, 200, 2, 1, 3, 6);
    phase(10, 10, 3, 3, 6, 10);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
